// ===== rtl/core/ray_box_intersect_core_defines.svh =====
// assertion macros for the ray/box core
`ifndef RAY_BOX_INTERSECT_CORE_DEFINES_SVH
`define RAY_BOX_INTERSECT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RBI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ray box core check failed");
`define RBI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ray box core check failed");
`else
`define RBI_ASSERT_NOW(label, ante, cons)
`define RBI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/rbi_pkg.sv =====
// ----------------------------------------------------------------------------
// rbi_pkg
// shared types of the ray/box intersection core
// ----------------------------------------------------------------------------
package rbi_pkg;

    typedef enum logic [1:0] {
        SIDE_ABOVE   = 2'd0,
        SIDE_BELOW   = 2'd1,
        SIDE_BETWEEN = 2'd2
    } side_t;

    typedef struct packed {
        logic            in_box;
        logic            miss;
        logic [1:0]      win;
        side_t [2:0]     side;
    } rbi_ctl_t;

endpackage

// ===== rtl/core/rbi_if.sv =====
// ----------------------------------------------------------------------------
// rbi_in_if / rbi_out_if
// valid/ready channels carrying ray/box items and hit results
// ----------------------------------------------------------------------------
interface rbi_in_if #(parameter int W = 32) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] box_min_x;
    logic signed [W-1:0] box_min_y;
    logic signed [W-1:0] box_min_z;
    logic signed [W-1:0] box_max_x;
    logic signed [W-1:0] box_max_y;
    logic signed [W-1:0] box_max_z;
    logic signed [W-1:0] origin_x;
    logic signed [W-1:0] origin_y;
    logic signed [W-1:0] origin_z;
    logic signed [W-1:0] heading_x;
    logic signed [W-1:0] heading_y;
    logic signed [W-1:0] heading_z;

    modport source (
        output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        output origin_x, origin_y, origin_z, heading_x, heading_y, heading_z,
        input  ready
    );
    modport sink (
        input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        input  origin_x, origin_y, origin_z, heading_x, heading_y, heading_z,
        output ready
    );
endinterface

interface rbi_out_if #(parameter int W = 32) ();
    logic                valid;
    logic                ready;
    logic                is_hit;
    logic                started_inside;
    logic signed [W-1:0] hit_x;
    logic signed [W-1:0] hit_y;
    logic signed [W-1:0] hit_z;

    modport source (
        output valid, is_hit, started_inside, hit_x, hit_y, hit_z,
        input  ready
    );
    modport sink (
        input  valid, is_hit, started_inside, hit_x, hit_y, hit_z,
        output ready
    );
endinterface

// ===== rtl/core/rbi_divider.sv =====
// ----------------------------------------------------------------------------
// rbi_divider
// pipelined restoring divider, one quotient bit per stage, fraction appended
// ----------------------------------------------------------------------------
module rbi_divider #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [W:0]           an,
    input  logic [W-1:0]         ad,
    output logic [W+F:0]         q
);
    localparam int QW = W + 1 + F;

    logic [W-1:0]  rem_reg [QW];
    logic [QW-1:0] nq_reg  [QW];
    logic [W-1:0]  d_reg   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [W-1:0]  rin;
        logic [QW-1:0] nin;
        logic [W-1:0]  din;
        logic [W:0]    trial;
        logic          qbit;
        logic [W-1:0]  rem_next;
        logic [QW-1:0] nq_next;

        if (k == 0) begin : g_first
            assign rin = '0;
            assign nin = {an, {F{1'b0}}};
            assign din = ad;
        end
        else begin : g_rest
            assign rin = rem_reg[k-1];
            assign nin = nq_reg[k-1];
            assign din = d_reg[k-1];
        end

        // shift one numerator bit into the partial remainder
        assign trial    = {rin, nin[QW-1]};
        assign qbit     = (trial >= {1'b0, din});
        assign rem_next = qbit ? W'(trial - {1'b0, din}) : trial[W-1:0];
        assign nq_next  = {nin[QW-2:0], qbit};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                nq_reg[k]  <= nq_next;
                d_reg[k]   <= din;
            end
        end
    end

    assign q = nq_reg[QW-1];
endmodule

// ===== rtl/core/rbi_hitpoint.sv =====
// ----------------------------------------------------------------------------
// rbi_hitpoint
// hit coordinates on the losing axes, one-sided bound test, result register
// ----------------------------------------------------------------------------
module rbi_hitpoint
    import rbi_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                 clk,
    input  logic                 en,
    input  rbi_ctl_t             ctl,
    input  logic [2:0][W-1:0]    lo,
    input  logic [2:0][W-1:0]    hi,
    input  logic [2:0][W-1:0]    org,
    input  logic [2:0][W-1:0]    dir,
    input  logic [W-1:0]         tw,
    output logic                 is_hit,
    output logic                 started_inside,
    output logic [2:0][W-1:0]    hit
);
    localparam int L  = W / 2;
    localparam int PW = 2 * W + 1;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] CMAX_S = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] CMIN_S = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [PW-1:0] RND    = {{(PW-F){1'b0}}, {F{1'b1}}};

    // stage e: partial products
    logic signed [W+L:0]   plo_reg [3];
    logic signed [2*W-L:0] phi_reg [3];
    rbi_ctl_t              ctl_e_reg;
    logic [2:0][W-1:0]     lo_e_reg, hi_e_reg, org_e_reg;

    // stage f: scaled products
    logic signed [PW-1:0]  s_reg [3];
    rbi_ctl_t              ctl_f_reg;
    logic [2:0][W-1:0]     lo_f_reg, hi_f_reg, org_f_reg;

    // stage g: result
    logic                  is_hit_reg, inside_reg;
    logic [2:0][W-1:0]     hit_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                plo_reg[a] <= $signed(dir[a]) * $signed({1'b0, tw[L-1:0]});
                phi_reg[a] <= $signed(dir[a]) * $signed({1'b0, tw[W-1:L]});
            end
            ctl_e_reg <= ctl;
            lo_e_reg  <= lo;
            hi_e_reg  <= hi;
            org_e_reg <= org;
        end
    end

    logic signed [PW-1:0] s_next [3];
    always_comb
    begin
        logic signed [PW-1:0] prod;
        for (int a = 0; a < 3; a++)
        begin
            prod = (PW'(phi_reg[a]) <<< L) + PW'(plo_reg[a]);
            // truncate toward zero
            if (prod[PW-1])
                prod = prod + RND;
            s_next[a] = prod >>> F;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
                s_reg[a] <= s_next[a];
            ctl_f_reg <= ctl_e_reg;
            lo_f_reg  <= lo_e_reg;
            hi_f_reg  <= hi_e_reg;
            org_f_reg <= org_e_reg;
        end
    end

    logic              is_hit_next, inside_next;
    logic [2:0][W-1:0] hit_next;
    always_comb
    begin
        logic signed [SW-1:0] sum;
        logic [2:0][W-1:0]    pt;
        logic                 ok;
        ok = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            sum = SW'(s_reg[a]) + SW'($signed(org_f_reg[a]));
            if (sum > CMAX_S)
                pt[a] = CMAX_S[W-1:0];
            else if (sum < CMIN_S)
                pt[a] = CMIN_S[W-1:0];
            else
                pt[a] = sum[W-1:0];
            if (a == int'(ctl_f_reg.win))
                pt[a] = (ctl_f_reg.side[a] == SIDE_BELOW) ? lo_f_reg[a] : hi_f_reg[a];
            else
            begin
                // only the bound on the far side is checked
                if (ctl_f_reg.side[a] == SIDE_ABOVE && $signed(pt[a]) < $signed(lo_f_reg[a]))
                    ok = 1'b0;
                if (ctl_f_reg.side[a] == SIDE_BELOW && $signed(pt[a]) > $signed(hi_f_reg[a]))
                    ok = 1'b0;
            end
        end
        if (ctl_f_reg.in_box)
        begin
            is_hit_next = 1'b1;
            inside_next = 1'b1;
            hit_next    = org_f_reg;
        end
        else if (ctl_f_reg.miss || !ok)
        begin
            is_hit_next = 1'b0;
            inside_next = 1'b0;
            hit_next    = '0;
        end
        else
        begin
            is_hit_next = 1'b1;
            inside_next = 1'b0;
            hit_next    = pt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            is_hit_reg <= is_hit_next;
            inside_reg <= inside_next;
            hit_reg    <= hit_next;
        end
    end

    assign is_hit         = is_hit_reg;
    assign started_inside = inside_reg;
    assign hit            = hit_reg;
endmodule

// ===== rtl/core/ray_box_intersect_core.sv =====
// ----------------------------------------------------------------------------
// ray_box_intersect_core
// ray against axis-aligned box, candidate-plane method, signed fixed point
// ----------------------------------------------------------------------------
// One ray/box item is accepted per cycle and one result comes out per item,
// in order, after one classify stage, one stage per quotient bit of the
// three parallel dividers, a clamp stage, a winner stage and three stages
// for the hit point multiply, rounding and bound test (Q16.16 at the
// default). The whole pipeline holds when the result at the output is not
// taken.
`include "ray_box_intersect_core_defines.svh"
module ray_box_intersect_core
    import rbi_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    rbi_in_if.sink    ray_in,
    rbi_out_if.source hit_out
);
    localparam int W  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int QW = W + 1 + F;
    localparam int NV = QW + 6;
    localparam logic [W-1:0] MINUS_ONE = W'(-(64'sd1 <<< F));

    typedef struct packed {
        logic [2:0][W-1:0] lo;
        logic [2:0][W-1:0] hi;
        logic [2:0][W-1:0] org;
        logic [2:0][W-1:0] dir;
        side_t [2:0]       side;
        logic [2:0]        neg;
        logic              in_box;
    } sb_t;

    logic          adv;
    logic [NV-1:0] vpipe_reg;

    assign adv          = !vpipe_reg[NV-1] || hit_out.ready;
    assign ray_in.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vpipe_reg <= '0;
        else if (adv)
            vpipe_reg <= {vpipe_reg[NV-2:0], ray_in.valid};
    end

    // classify stage
    logic [2:0][W-1:0] lo_in, hi_in, org_in, dir_in;
    assign lo_in  = {ray_in.box_min_z, ray_in.box_min_y, ray_in.box_min_x};
    assign hi_in  = {ray_in.box_max_z, ray_in.box_max_y, ray_in.box_max_x};
    assign org_in = {ray_in.origin_z, ray_in.origin_y, ray_in.origin_x};
    assign dir_in = {ray_in.heading_z, ray_in.heading_y, ray_in.heading_x};

    sb_t          sb_next;
    logic [W:0]   an_next [3];
    logic [W-1:0] ad_next [3];
    always_comb
    begin
        logic signed [W:0] n;
        logic [W-1:0]      plane;
        sb_next.lo     = lo_in;
        sb_next.hi     = hi_in;
        sb_next.org    = org_in;
        sb_next.dir    = dir_in;
        sb_next.in_box = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            if ($signed(org_in[a]) < $signed(lo_in[a]))
            begin
                sb_next.side[a] = SIDE_BELOW;
                plane           = lo_in[a];
                sb_next.in_box  = 1'b0;
            end
            else if ($signed(org_in[a]) > $signed(hi_in[a]))
            begin
                sb_next.side[a] = SIDE_ABOVE;
                plane           = hi_in[a];
                sb_next.in_box  = 1'b0;
            end
            else
            begin
                sb_next.side[a] = SIDE_BETWEEN;
                plane           = '0;
            end
            n             = (W+1)'($signed(plane)) - (W+1)'($signed(org_in[a]));
            an_next[a]    = n[W] ? (W+1)'(-n) : n;
            ad_next[a]    = dir_in[a][W-1] ? W'(-dir_in[a]) : dir_in[a];
            sb_next.neg[a] = n[W] ^ dir_in[a][W-1];
        end
    end

    sb_t          sba_reg;
    logic [W:0]   an_reg [3];
    logic [W-1:0] ad_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sba_reg <= sb_next;
            for (int a = 0; a < 3; a++)
            begin
                an_reg[a] <= an_next[a];
                ad_reg[a] <= ad_next[a];
            end
        end
    end

    // divider stages, item context rides alongside
    logic [QW-1:0] q [3];
    for (genvar a = 0; a < 3; a++) begin : g_div
        rbi_divider #(.W(W), .F(F)) u_div (
            .clk (clk),
            .en  (adv),
            .an  (an_reg[a]),
            .ad  (ad_reg[a]),
            .q   (q[a])
        );
    end

    sb_t sbd_reg [QW];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sbd_reg[0] <= sba_reg;
            for (int k = 1; k < QW; k++)
                sbd_reg[k] <= sbd_reg[k-1];
        end
    end

    // clamp stage
    logic [2:0][W-1:0] t_next;
    always_comb
    begin
        logic [W-1:0] capv;
        logic [W-1:0] qs;
        for (int a = 0; a < 3; a++)
        begin
            capv = sbd_reg[QW-1].neg[a] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            qs   = (q[a] > QW'(capv)) ? capv : q[a][W-1:0];
            if (sbd_reg[QW-1].side[a] == SIDE_BETWEEN || sbd_reg[QW-1].dir[a] == '0)
                t_next[a] = MINUS_ONE;
            else
                t_next[a] = sbd_reg[QW-1].neg[a] ? W'(-qs) : qs;
        end
    end

    sb_t               sbc_reg;
    logic [2:0][W-1:0] t_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sbc_reg <= sbd_reg[QW-1];
            t_reg   <= t_next;
        end
    end

    // winner stage, ties keep the earlier axis
    logic [1:0]   win_next;
    logic [W-1:0] tw_next;
    always_comb
    begin
        win_next = ($signed(t_reg[0]) < $signed(t_reg[1])) ? 2'd1 : 2'd0;
        if ($signed(t_reg[win_next]) < $signed(t_reg[2]))
            win_next = 2'd2;
        tw_next = t_reg[win_next];
    end

    sb_t          sbw_reg;
    rbi_ctl_t     ctl_reg;
    logic [W-1:0] tw_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sbw_reg        <= sbc_reg;
            tw_reg         <= tw_next;
            ctl_reg.in_box <= sbc_reg.in_box;
            ctl_reg.miss   <= tw_next[W-1];
            ctl_reg.win    <= win_next;
            ctl_reg.side   <= sbc_reg.side;
        end
    end

    logic [2:0][W-1:0] hit;
    rbi_hitpoint #(.W(W), .F(F)) u_hit (
        .clk            (clk),
        .en             (adv),
        .ctl            (ctl_reg),
        .lo             (sbw_reg.lo),
        .hi             (sbw_reg.hi),
        .org            (sbw_reg.org),
        .dir            (sbw_reg.dir),
        .tw             (tw_reg),
        .is_hit         (hit_out.is_hit),
        .started_inside (hit_out.started_inside),
        .hit            (hit)
    );

    assign hit_out.valid = vpipe_reg[NV-1];
    assign hit_out.hit_x = hit[0];
    assign hit_out.hit_y = hit[1];
    assign hit_out.hit_z = hit[2];

    `RBI_ASSERT_NOW(a_inside_is_hit, hit_out.valid && hit_out.started_inside, hit_out.is_hit)
    `RBI_ASSERT_NOW(a_miss_zero, hit_out.valid && !hit_out.is_hit, hit == '0)
    `RBI_ASSERT_NEXT(a_stall_hold, !adv, vpipe_reg == $past(vpipe_reg))
    `RBI_ASSERT_NOW(a_ready_when_empty, !hit_out.valid, ray_in.ready)
endmodule

// ===== tb/sv/ray_box_intersect_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_intersect_core_tb
// checks ray/box hit results against a candidate-plane predictor, with random
// gaps on both channels and one long output stall that backs up the pipeline
// ----------------------------------------------------------------------------
module ray_box_intersect_core_tb;
    import rbi_pkg::*;

    localparam int W    = 32;
    localparam int FRAC = 16;
    localparam int PIPE_DEPTH = W + FRAC + 7;

    localparam logic signed [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] NEG_ONE   = W'(-(64'sd1 <<< FRAC));

    typedef struct {
        logic signed [W-1:0] lo [3];
        logic signed [W-1:0] hi [3];
        logic signed [W-1:0] org [3];
        logic signed [W-1:0] dir [3];
    } ray_box_t;

    typedef struct {
        logic                is_hit;
        logic                started_inside;
        logic signed [W-1:0] pt [3];
    } hit_t;

    logic clk;
    logic rst_n;
    int   fail_count;
    bit   hold_off;

    hit_t pending_hits [$];

    rbi_in_if  #(.W(W)) ray_in ();
    rbi_out_if #(.W(W)) hit_out ();

    ray_box_intersect_core #(.COORD_WIDTH(W), .FRAC_BITS(FRAC)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .ray_in  (ray_in),
        .hit_out (hit_out)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // fixed point divide, truncated toward zero, saturated
    function automatic logic signed [W-1:0] fx_div(logic signed [W:0] n,
                                                  logic signed [W-1:0] d);
        logic [W:0]        an;
        logic [W-1:0]      ad;
        logic [W+FRAC:0]   q;
        logic [W:0]        cap;
        logic              neg;
        neg = (n < 0) != (d < 0);
        an  = n < 0 ? -n : n;
        ad  = d < 0 ? -d : d;
        cap = neg ? {2'b01, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};
        q   = ({an, {FRAC{1'b0}}}) / ad;
        if (q > cap)
            q = cap;
        return neg ? -q[W-1:0] : q[W-1:0];
    endfunction

    // fixed point multiply, truncated toward zero, clamped to +-2^W
    function automatic logic signed [W+1:0] fx_mul(logic signed [W-1:0] a,
                                                  logic signed [W-1:0] b);
        logic [2*W-1:0] p;
        logic [2*W-1:0] r;
        logic           neg;
        neg = (a < 0) != (b < 0);
        p   = (a < 0 ? -{{W{a[W-1]}}, a} : {{W{1'b0}}, a}) *
              (b < 0 ? -{{W{b[W-1]}}, b} : {{W{1'b0}}, b});
        r   = p >> FRAC;
        if (r > (64'd1 << W))
            r = 64'd1 << W;
        return neg ? -$signed({1'b0, r[W:0]}) : $signed({1'b0, r[W:0]});
    endfunction

    function automatic hit_t predict_hit(ray_box_t rb);
        hit_t                res;
        side_t               side [3];
        logic signed [W-1:0] plane [3];
        logic signed [W-1:0] tdist [3];
        logic signed [W+2:0] sum;
        logic                in_box;
        logic                ok;
        int                  win;
        in_box = 1'b1;
        ok     = 1'b1;
        win    = 0;
        res.is_hit = 1'b0;
        res.started_inside = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            res.pt[i] = '0;
            plane[i]  = '0;
            if (rb.org[i] < rb.lo[i])
            begin
                side[i] = SIDE_BELOW;
                plane[i] = rb.lo[i];
                in_box = 1'b0;
            end
            else if (rb.org[i] > rb.hi[i])
            begin
                side[i] = SIDE_ABOVE;
                plane[i] = rb.hi[i];
                in_box = 1'b0;
            end
            else
                side[i] = SIDE_BETWEEN;
        end
        if (in_box)
        begin
            res.is_hit = 1'b1;
            res.started_inside = 1'b1;
            res.pt = rb.org;
            return res;
        end
        for (int i = 0; i < 3; i++)
            tdist[i] = (side[i] == SIDE_BETWEEN || rb.dir[i] == 0) ? NEG_ONE :
                fx_div($signed({plane[i][W-1], plane[i]}) -
                       $signed({rb.org[i][W-1], rb.org[i]}), rb.dir[i]);
        for (int i = 1; i < 3; i++)
            if (tdist[win] < tdist[i])
                win = i;
        if (tdist[win] < 0)
            return res;
        for (int i = 0; i < 3; i++)
        begin
            if (i == win)
            begin
                res.pt[i] = plane[i];
                continue;
            end
            sum = fx_mul(rb.dir[i], tdist[win]) + rb.org[i];
            res.pt[i] = sum > COORD_MAX ? COORD_MAX :
                        sum < COORD_MIN ? COORD_MIN : sum[W-1:0];
            if (side[i] == SIDE_ABOVE && res.pt[i] < rb.lo[i])
                ok = 1'b0;
            if (side[i] == SIDE_BELOW && res.pt[i] > rb.hi[i])
                ok = 1'b0;
        end
        if (!ok)
        begin
            res.pt[0] = '0;
            res.pt[1] = '0;
            res.pt[2] = '0;
            return res;
        end
        res.is_hit = 1'b1;
        return res;
    endfunction

    // valid stays up into the next item when there is no gap
    task automatic send_ray(ray_box_t rb);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            ray_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ray_in.valid     <= 1'b1;
        ray_in.box_min_x <= rb.lo[0];
        ray_in.box_min_y <= rb.lo[1];
        ray_in.box_min_z <= rb.lo[2];
        ray_in.box_max_x <= rb.hi[0];
        ray_in.box_max_y <= rb.hi[1];
        ray_in.box_max_z <= rb.hi[2];
        ray_in.origin_x  <= rb.org[0];
        ray_in.origin_y  <= rb.org[1];
        ray_in.origin_z  <= rb.org[2];
        ray_in.heading_x <= rb.dir[0];
        ray_in.heading_y <= rb.dir[1];
        ray_in.heading_z <= rb.dir[2];
        @(posedge clk);
        while (!ray_in.ready)
            @(posedge clk);
        pending_hits.push_back(predict_hit(rb));
    endtask

    function automatic logic signed [W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3, 4: return $signed($urandom);
            default: return $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
        endcase
    endfunction

    // mostly well-formed box, random origin, heading mostly toward the box
    function automatic ray_box_t rand_ray();
        ray_box_t rb;
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
        for (int i = 0; i < 3; i++)
        begin
            a = rand_coord();
            b = rand_coord();
            if ($urandom_range(0, 9) != 0 && a > b)
            begin
                rb.lo[i] = b;
                rb.hi[i] = a;
            end
            else
            begin
                rb.lo[i] = a;
                rb.hi[i] = b;
            end
            rb.org[i] = rand_coord();
            rb.dir[i] = $urandom_range(0, 5) == 0 ? '0 : rand_coord();
            if ($urandom_range(0, 2) != 0)
            begin
                if (rb.org[i] < rb.lo[i] && rb.dir[i] < 0)
                    rb.dir[i] = -rb.dir[i];
                if (rb.org[i] > rb.hi[i] && rb.dir[i] > 0)
                    rb.dir[i] = -rb.dir[i];
            end
        end
        return rb;
    endfunction

    function automatic ray_box_t make_ray(int x0, int y0, int z0, int x1, int y1, int z1,
                                          int ox, int oy, int oz, int dx, int dy, int dz);
        ray_box_t rb;
        rb.lo  = '{x0, y0, z0};
        rb.hi  = '{x1, y1, z1};
        rb.org = '{ox, oy, oz};
        rb.dir = '{dx, dy, dz};
        return rb;
    endfunction

    task automatic test_directed();
        int U;
        U = 1 << FRAC;
        send_ray(make_ray(-U, -U, -U, U, U, U, 0, 0, 0, U, 0, 0));
        send_ray(make_ray(-U, -U, -U, U, U, U, -4*U, 0, 0, U, 0, 0));
        send_ray(make_ray(-U, -U, -U, U, U, U, 4*U, 0, 0, -U, 0, 0));
        send_ray(make_ray(-U, -U, -U, U, U, U, 4*U, 0, 0, U, 0, 0));
        send_ray(make_ray(-U, -U, -U, U, U, U, 4*U, 0, 0, 0, 0, 0));
        send_ray(make_ray(-U, -U, -U, U, U, U, 4*U, 4*U, 0, -U, -U, 0));
        send_ray(make_ray(-U, -U, -U, U, U, U, 4*U, 4*U, 4*U, -U, -U, -U));
        send_ray(make_ray(-U, -U, -U, U, U, U, 4*U, 5*U, 0, -U, -U, 0));
        send_ray(make_ray(-U, -U, -U, U, U, U, 4*U, 3*U, 0, -U, -3*U, 0));
        send_ray(make_ray(-U, -U, -U, U, U, U, -4*U, 3*U, 0, U, 5*U, 0));
        send_ray(make_ray(U, U, U, -U, -U, -U, 0, 0, 0, U, U, U));
        send_ray(make_ray(-U, -U, -U, U, U, U, 0, 0, 4*U, 1, 1, -1));
        send_ray(make_ray(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                          COORD_MAX, COORD_MIN, 0, 0, 0, 0));
        send_ray(make_ray(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                          COORD_MIN, COORD_MIN, COORD_MIN, 1, COORD_MAX, 1));
        send_ray(make_ray(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                          COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, -1, COORD_MIN));
        send_ray(make_ray(0, 0, 0, U, U, U, COORD_MIN, U/2, U/2, 1, COORD_MAX, COORD_MIN));
        send_ray(make_ray(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++)
            send_ray(rand_ray());
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (3 * PIPE_DEPTH) @(posedge clk);
                hold_off = 1'b0;
            end
            test_random(2 * PIPE_DEPTH);
        join
    endtask

    // result side: random stalls, plus a forced stall while hold_off is set
    initial
    begin
        int stall;
        hit_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 5);
            if ($urandom_range(0, 3) == 0)
                stall = 0;
            if (stall != 0 || hold_off)
            begin
                hit_out.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (hold_off)
                    @(posedge clk);
            end
            hit_out.ready <= 1'b1;
            @(posedge clk);
            while (!hit_out.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        hit_t want;
        if (rst_n && hit_out.valid && hit_out.ready)
        begin
            if (pending_hits.size() == 0)
            begin
                $error("result with no item pending");
                fail_count++;
            end
            else
            begin
                want = pending_hits.pop_front();
                if (hit_out.is_hit !== want.is_hit)
                begin
                    $error("is_hit: expected %0d, got %0d", want.is_hit, hit_out.is_hit);
                    fail_count++;
                end
                if (hit_out.started_inside !== want.started_inside)
                begin
                    $error("started_inside: expected %0d, got %0d",
                           want.started_inside, hit_out.started_inside);
                    fail_count++;
                end
                if (hit_out.hit_x !== want.pt[0])
                begin
                    $error("hit_x: expected %h, got %h", want.pt[0], hit_out.hit_x);
                    fail_count++;
                end
                if (hit_out.hit_y !== want.pt[1])
                begin
                    $error("hit_y: expected %h, got %h", want.pt[1], hit_out.hit_y);
                    fail_count++;
                end
                if (hit_out.hit_z !== want.pt[2])
                begin
                    $error("hit_z: expected %h, got %h", want.pt[2], hit_out.hit_z);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int drain;
        fail_count = 0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        ray_in.valid = 1'b0;
        ray_in.box_min_x = '0;
        ray_in.box_min_y = '0;
        ray_in.box_min_z = '0;
        ray_in.box_max_x = '0;
        ray_in.box_max_y = '0;
        ray_in.box_max_z = '0;
        ray_in.origin_x = '0;
        ray_in.origin_y = '0;
        ray_in.origin_z = '0;
        ray_in.heading_x = '0;
        ray_in.heading_y = '0;
        ray_in.heading_z = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(600);
        test_backpressure();
        test_random(480);
        ray_in.valid <= 1'b0;
        drain = 0;
        while (pending_hits.size() != 0 && drain < 200 * PIPE_DEPTH)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (PIPE_DEPTH + 10) @(posedge clk);
        if (fail_count == 0 && pending_hits.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
